// ----- hdl/button_long_press_level_detector_top_macros.svh -----
// assertion macros for the long-press level detector checker
// no dependencies; included by the checker file only
`ifndef BUTTON_LONG_PRESS_LEVEL_DETECTOR_TOP_MACROS_SVH
`define BUTTON_LONG_PRESS_LEVEL_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, skipped while reset is asserted
`define BLPD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blpd assertion failed");

// next-cycle implication, skipped while reset is asserted
`define BLPD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blpd assertion failed");

`endif

// ----- hdl/blpd_pkg.sv -----
// shared types, register codes and constants of the long-press level detector
// no dependencies
package blpd_pkg;

	localparam int TimeW = 32;
	localparam int LevelW = 3;
	localparam int FreqW = 12;
	localparam int NumThresholds = 7;
	localparam int RegIndexW = 3;
	localparam int BuzzStepHz = 400;

	typedef enum logic [RegIndexW-1:0] {
		REG_PRESS_POL = 3'd0,
		REG_THRESHOLD_1 = 3'd1,
		REG_THRESHOLD_2 = 3'd2,
		REG_THRESHOLD_3 = 3'd3,
		REG_THRESHOLD_4 = 3'd4,
		REG_THRESHOLD_5 = 3'd5,
		REG_THRESHOLD_6 = 3'd6,
		REG_THRESHOLD_7 = 3'd7
	} blpd_reg_e;

	// entry 0 belongs to level 1
	localparam logic [NumThresholds-1:0][TimeW-1:0] ThresholdReset = {
		32'd8000, 32'd5000, 32'd4000, 32'd3000, 32'd2000, 32'd1000, 32'd500
	};

	typedef struct packed {
		logic press_pol;
		logic [NumThresholds-1:0][TimeW-1:0] threshold;
	} blpd_cfg_t;

	// buzzer tone for a level; the buzzer duration is not output
	function automatic logic [FreqW-1:0] buzz_freq(input logic [LevelW-1:0] lvl);
		logic [FreqW-1:0] f;
		f = FreqW'(BuzzStepHz * int'(lvl));
		return f;
	endfunction

endpackage

// ----- hdl/blpd_ifs.sv -----
// valid/ready channel interfaces for pin samples and detector results
// no dependencies
interface blpd_sample_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic [31:0] time_ms;

	modport source(output valid, output pin_level, output time_ms, input ready);
	modport sink(input valid, input pin_level, input time_ms, output ready);
endinterface

interface blpd_result_if;
	logic valid;
	logic ready;
	logic is_pressed;
	logic changed;
	logic released;
	logic [2:0] press_level;
	logic level_raised;
	logic buzz_request;
	logic [11:0] buzz_freq_hz;

	modport source(output valid, output is_pressed, output changed, output released,
		output press_level, output level_raised, output buzz_request,
		output buzz_freq_hz, input ready);
	modport sink(input valid, input is_pressed, input changed, input released,
		input press_level, input level_raised, input buzz_request,
		input buzz_freq_hz, output ready);
endinterface

// ----- hdl/blpd_cfg_regs.sv -----
// configuration registers: active level and the seven hold thresholds
// depends on blpd_pkg
module blpd_cfg_regs
	import blpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [RegIndexW-1:0] wr_index,
	input  logic [TimeW-1:0]     wr_data,
	output blpd_cfg_t            cfg
);

	blpd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_pol <= 1'b0;
			cfg_q.threshold <= ThresholdReset;
		end else if (wr_en) begin
			if (wr_index == REG_PRESS_POL) begin
				cfg_q.press_pol <= wr_data[0];
			end else begin
				cfg_q.threshold[wr_index - 3'd1] <= wr_data;
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/blpd_level_pick.sv -----
// elapsed hold time and threshold compare with priority pick of the highest level
// depends on blpd_pkg
module blpd_level_pick
	import blpd_pkg::*;
#(
	parameter int NUM_LEVELS = 8
) (
	input  logic [TimeW-1:0]  now,
	input  logic [TimeW-1:0]  start,
	input  blpd_cfg_t         cfg,
	output logic [LevelW-1:0] level
);

	localparam int Clamped = (NUM_LEVELS < 2) ? 2 : ((NUM_LEVELS > 8) ? 8 : NUM_LEVELS);
	localparam int TopLevel = Clamped - 1;

	logic [TimeW-1:0] elapsed;

	// wraps modulo 2^32
	assign elapsed = now - start;

	// ascending scan, so the highest level that is met wins
	always_comb begin
		level = '0;
		for (int j = 1; j <= TopLevel; j++) begin
			if (elapsed >= cfg.threshold[j-1]) begin
				level = LevelW'(j);
			end
		end
	end

endmodule

// ----- hdl/button_long_press_level_detector_top.sv -----
// Button long-press level detector, top level.
// Depends on blpd_pkg, blpd_ifs, blpd_cfg_regs and blpd_level_pick.
//
// sample channel (sink): pin_level and a wrapping millisecond timestamp time_ms.
// result channel (source): is_pressed, changed, released, press_level,
//   level_raised, buzz_request and buzz_freq_hz (400 Hz per level, 0 with no request).
// wr_en/wr_index/wr_data write the active level (index 0) and thresholds 1..7;
//   write them only while no result is outstanding.
// Latency: the result of a sample is valid in the cycle after its transfer.
// Throughput: one sample per cycle unless the receiver stalls. All work is one
//   combinational pass (a 32-bit subtract, seven parallel compares and a priority
//   pick) into the result register. On a stall the result register holds and the
//   sample side still takes a new item in the cycle the held result is taken.
// Reset clears the previous sample, the press start time and the held level to
//   zero and loads the threshold defaults; there is no clearing pass.
module button_long_press_level_detector_top
	import blpd_pkg::*;
#(
	parameter int NUM_LEVELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	blpd_sample_if.sink          sample,
	blpd_result_if.source        result,
	input  logic                 wr_en,
	input  logic [RegIndexW-1:0] wr_index,
	input  logic [TimeW-1:0]     wr_data
);

	blpd_cfg_t cfg;
	logic [LevelW-1:0] pick_level;

	logic accept;
	logic pressed;
	logic changed;
	logic raised;
	logic [LevelW-1:0] next_level;

	logic prev_sample_q;
	logic [TimeW-1:0] press_start_q;
	logic [LevelW-1:0] held_level_q;

	logic out_valid_q;
	logic is_pressed_q;
	logic changed_q;
	logic released_q;
	logic [LevelW-1:0] press_level_q;
	logic raised_q;
	logic request_q;
	logic [FreqW-1:0] freq_q;

	blpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	blpd_level_pick #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_pick (
		.now   (sample.time_ms),
		.start (press_start_q),
		.cfg   (cfg),
		.level (pick_level)
	);

	assign sample.ready = !out_valid_q || result.ready;
	assign accept = sample.valid && sample.ready;

	always_comb begin
		pressed = (sample.pin_level == cfg.press_pol);
		changed = (sample.pin_level != prev_sample_q);
		raised = 1'b0;
		next_level = held_level_q;
		if (changed) begin
			if (pressed) begin
				next_level = '0;
			end
		end else if (pressed && (pick_level > held_level_q)) begin
			next_level = pick_level;
			raised = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q <= 1'b0;
			press_start_q <= '0;
			held_level_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_sample_q <= sample.pin_level;
				held_level_q <= next_level;
				out_valid_q <= 1'b1;
				if (changed && pressed) begin
					press_start_q <= sample.time_ms;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only on a sample transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			is_pressed_q <= pressed;
			changed_q <= changed;
			released_q <= changed && !pressed;
			press_level_q <= next_level;
			raised_q <= raised;
			request_q <= raised && (next_level != '0);
			freq_q <= (raised && (next_level != '0)) ? buzz_freq(next_level) : '0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.is_pressed = is_pressed_q;
	assign result.changed = changed_q;
	assign result.released = released_q;
	assign result.press_level = press_level_q;
	assign result.level_raised = raised_q;
	assign result.buzz_request = request_q;
	assign result.buzz_freq_hz = freq_q;

endmodule

// ----- hdl/blpd_checker.sv -----
// port-level checker for the long-press level detector, bound to the top level
// depends on button_long_press_level_detector_top_macros.svh
`include "button_long_press_level_detector_top_macros.svh"

module blpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        is_pressed,
	input logic        changed,
	input logic        released,
	input logic [2:0]  press_level,
	input logic        level_raised,
	input logic        buzz_request,
	input logic [11:0] buzz_freq_hz
);

	// a stalled result holds its level and tone
	`BLPD_ASSERT_NXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(press_level) && $stable(buzz_freq_hz))

	// a release is a change to the inactive level and never raises a level
	`BLPD_ASSERT_IMP(a_release_edge, clk, arst_n, res_valid && released, changed && !is_pressed && !level_raised)

	// a tone request comes only with a rise to a nonzero level
	`BLPD_ASSERT_IMP(a_req_raise, clk, arst_n, res_valid && buzz_request, level_raised && (press_level != 3'd0) && (buzz_freq_hz != 12'd0))

	// no request means a silent tone field
	`BLPD_ASSERT_IMP(a_no_req_quiet, clk, arst_n, res_valid && !buzz_request, buzz_freq_hz == 12'd0)

endmodule

bind button_long_press_level_detector_top blpd_checker u_blpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.is_pressed   (result.is_pressed),
	.changed      (result.changed),
	.released     (result.released),
	.press_level  (result.press_level),
	.level_raised (result.level_raised),
	.buzz_request (result.buzz_request),
	.buzz_freq_hz (result.buzz_freq_hz)
);
